### src/bcpe_pkg.sv
// Package with the shared types and constants of the Bezier curve point evaluator.
package bcpe_pkg;

    localparam int MAX_POINTS_DEF  = 16;
    localparam int COORD_BITS_DEF  = 16;
    localparam int DEG_BITS        = 4;
    localparam int INDEX_BITS      = 4;
    localparam int T_BITS          = 17;
    localparam int T_FRAC          = 16;
    localparam logic [T_BITS-1:0] T_ONE = 17'h10000;
    localparam logic [DEG_BITS-1:0] DEGREE_RESET = 4'd3;

    typedef enum logic
    {
        REQ_LOAD = 1'b0,
        REQ_EVAL = 1'b1
    } req_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

### src/bezier_curve_point_eval.sv
// Bezier curve point evaluator: control point store and de Casteljau evaluation engine.
//
// A transfer with tuser low loads one control point; a transfer with tuser high evaluates
// the curve of the configured degree n at t and returns one point on the master side.
// Each level of de Casteljau streams through a working memory, one interpolation of all
// three coordinates per cycle, read one entry ahead with a single read port; each level
// then drains the read pipeline before the next level reads its results. Degree zero
// still passes point 0 through the read pipeline. No further transfer is accepted from
// an accepted evaluation until its result has been handed to the output register. Loads
// are accepted while an earlier result still waits on the master side. No clearing pass is
// run after reset; points must be loaded before they are used.
module bezier_curve_point_eval #(
    parameter int MAX_POINTS = bcpe_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = bcpe_pkg::COORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [bcpe_pkg::DEG_BITS-1:0] cfg_wdata,
    input  logic s_tvalid,
    output logic s_tready,
    // from bit 0: point_index, point_x, point_y, point_z, param_t, zero fill
    input  logic [((bcpe_pkg::INDEX_BITS + 3*COORD_BITS + bcpe_pkg::T_BITS + 7)/8)*8-1:0] s_tdata,
    // req_type
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // from bit 0: curve_x, curve_y, curve_z, zero fill
    output logic [((3*COORD_BITS + 7)/8)*8-1:0] m_tdata
);
    import bcpe_pkg::*;

    localparam int CB      = COORD_BITS;
    localparam int IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int WORD_W  = 3*CB;
    localparam int M_W     = ((3*CB + 7)/8)*8;
    localparam int X_LO    = INDEX_BITS;
    localparam int T_LO    = INDEX_BITS + 3*CB;

    // u + floor(t*(v-u) / 2^16); the exact result lies between u and v, so truncation is safe
    function automatic logic [CB-1:0] lerp(input logic [CB-1:0] u, input logic [CB-1:0] v,
                                           input logic [T_BITS-1:0] t);
        logic signed [CB:0]      d;
        logic signed [CB+18:0]   p;
        logic [CB-1:0]           s;
        d = $signed({v[CB-1], v}) - $signed({u[CB-1], u});
        p = $signed({1'b0, t}) * d;
        s = p[CB+T_FRAC-1:T_FRAC];
        return u + s;
    endfunction

    state_t state_reg, state_next;

    logic [DEG_BITS-1:0] degree_reg;
    logic [T_BITS-1:0]   t_reg, t_next;
    logic [IDX_W-1:0]    n_reg, n_next;
    logic [IDX_W-1:0]    level_reg, level_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]    idx_d_reg;
    logic                rdv_reg;
    logic [WORD_W-1:0]   prev_reg;
    logic [WORD_W-1:0]   res_reg;
    logic [WORD_W-1:0]   out_reg;
    logic                m_tvalid_reg;

    logic [WORD_W-1:0]   pts_mem [MAX_POINTS];
    logic [WORD_W-1:0]   work_mem [MAX_POINTS];
    logic [WORD_W-1:0]   pts_q_reg;
    logic [WORD_W-1:0]   work_q_reg;

    logic                s_fire;
    logic                load_fire;
    logic                eval_fire;
    logic                out_free;
    logic [IDX_W-1:0]    last_idx;
    logic [WORD_W-1:0]   rd_data;
    logic [WORD_W-1:0]   lerp_word;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic [INDEX_BITS-1:0] in_index;
    logic [WORD_W-1:0]   in_point;
    logic [T_BITS-1:0]   in_t;

    assign in_index  = s_tdata[INDEX_BITS-1:0];
    assign in_point  = s_tdata[X_LO +: WORD_W];
    assign in_t      = s_tdata[T_LO +: T_BITS];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign load_fire = s_fire && (req_t'(s_tuser) == REQ_LOAD) && (int'(in_index) < MAX_POINTS);
    assign eval_fire = s_fire && (req_t'(s_tuser) == REQ_EVAL);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign t_next    = (in_t > T_ONE) ? T_ONE : in_t;
    assign n_next    = (int'(degree_reg) > MAX_POINTS - 1) ? IDX_W'(MAX_POINTS - 1)
                                                          : IDX_W'(degree_reg);

    // Level j reads entries 0 .. n-j+1; degree zero reads entry 0 alone
    assign last_idx  = (n_reg == '0) ? '0 : IDX_W'(n_reg - level_reg + IDX_W'(1));

    // Level one reads the control points, later levels the working copy
    assign rd_data   = (level_reg == IDX_W'(1)) ? pts_q_reg : work_q_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            lerp_word[c*CB +: CB] = lerp(prev_reg[c*CB +: CB], rd_data[c*CB +: CB], t_reg);
        end
    end

    assign wr_en  = rdv_reg && (idx_d_reg != '0);
    assign wr_idx = idx_d_reg - IDX_W'(1);

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (eval_fire)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (rd_idx_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rdv_reg)
                begin
                    state_next = (level_reg >= n_reg) ? ST_DONE : ST_READ;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer counters
    always_comb
    begin
        level_next  = level_reg;
        rd_idx_next = rd_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                level_next  = IDX_W'(1);
                rd_idx_next = '0;
            end
            ST_READ:
            begin
                if (rd_idx_reg != last_idx)
                begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!rdv_reg && (level_reg < n_reg))
                begin
                    level_next  = level_reg + IDX_W'(1);
                    rd_idx_next = '0;
                end
            end
            default:
            begin
                level_next  = level_reg;
                rd_idx_next = rd_idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            degree_reg   <= DEGREE_RESET;
            level_reg    <= IDX_W'(1);
            rd_idx_reg   <= '0;
            rdv_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            level_reg  <= level_next;
            rd_idx_reg <= rd_idx_next;
            rdv_reg    <= (state_reg == ST_READ);
            if (cfg_we)
            begin
                degree_reg <= cfg_wdata;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        idx_d_reg <= rd_idx_reg;
        if (eval_fire)
        begin
            t_reg <= t_next;
            n_reg <= n_next;
        end
        if (rdv_reg)
        begin
            prev_reg <= rd_data;
            if (idx_d_reg == '0)
            begin
                if (n_reg == '0)
                begin
                    res_reg <= rd_data;
                end
            end
            else if (level_reg == n_reg)
            begin
                res_reg <= lerp_word;
            end
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    // Control point store and working memory
    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            pts_mem[IDX_W'(in_index)] <= in_point;
        end
        pts_q_reg <= pts_mem[rd_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            work_mem[wr_idx] <= lerp_word;
        end
        work_q_reg <= work_mem[rd_idx_reg];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_W'(out_reg);

    // The read index never runs past the end of the current level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (rd_idx_reg <= last_idx))
        else $error("read index beyond the end of the level");

    // The result is only taken once the last interpolation has left the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !rdv_reg)
        else $error("result taken with a read still in flight");

    // The level counter stays within a nonzero degree while an evaluation runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && n_reg != '0) |-> (level_reg <= n_reg && level_reg != '0))
        else $error("level counter out of range");

    // A new result appears only when an evaluation completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result presented without a finished evaluation");

    // No working-memory write happens outside an evaluation.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_READ || state_reg == ST_DRAIN))
        else $error("working memory written while idle");

endmodule

### bench/tb_bezier_curve_point_eval.sv
// Self-checking testbench for the Bezier curve point evaluator, with a point-store scoreboard.
module tb_bezier_curve_point_eval;

    import bcpe_pkg::*;

    localparam int COORD = COORD_BITS_DEF;
    localparam int S_W = ((INDEX_BITS + 3*COORD + T_BITS + 7)/8)*8;
    localparam int M_W = ((3*COORD + 7)/8)*8;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 105;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT = 1500000;

    typedef logic signed [COORD-1:0] coord_t;
    // Packed so that coordinate c sits where the master-side tdata carries it.
    typedef logic [2:0][COORD-1:0] point_t;

    class curve_scoreboard;
        coord_t ctrl_pts [MAX_POINTS_DEF][3];
        logic [DEG_BITS-1:0] degree;
        point_t expected_points [$];
        int errors;

        function new();
            degree = DEGREE_RESET;
            errors = 0;
            foreach (ctrl_pts[i, c])
                ctrl_pts[i][c] = '0;
        endfunction

        function void set_degree(logic [DEG_BITS-1:0] d);
            degree = d;
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        // One interpolation step; the shift of the signed product rounds towards minus infinity.
        function coord_t lerp(coord_t u, coord_t v, logic [T_BITS-1:0] t);
            longint diff;
            longint prod;
            diff = longint'(v) - longint'(u);
            prod = longint'(t) * diff;
            return coord_t'(longint'(u) + (prod >>> T_FRAC));
        endfunction

        function point_t eval_point(logic [T_BITS-1:0] t_in);
            coord_t work [MAX_POINTS_DEF][3];
            logic [T_BITS-1:0] t;
            int n;
            point_t p;
            t = (t_in > T_ONE) ? T_ONE : t_in;
            n = int'(degree);
            if (n > MAX_POINTS_DEF - 1)
                n = MAX_POINTS_DEF - 1;
            for (int k = 0; k <= n; k++)
                for (int c = 0; c < 3; c++)
                    work[k][c] = ctrl_pts[k][c];
            for (int j = 1; j <= n; j++)
                for (int k = 0; k + j <= n; k++)
                    for (int c = 0; c < 3; c++)
                        work[k][c] = lerp(work[k][c], work[k+1][c], t);
            for (int c = 0; c < 3; c++)
                p[c] = work[0][c];
            return p;
        endfunction

        function void note_input(logic req, logic [S_W-1:0] data);
            logic [INDEX_BITS-1:0] idx;
            idx = data[INDEX_BITS-1:0];
            if (req_t'(req) == REQ_LOAD) begin
                for (int c = 0; c < 3; c++)
                    ctrl_pts[idx][c] = data[INDEX_BITS + c*COORD +: COORD];
            end
            else begin
                expected_points = {expected_points,
                                   eval_point(data[INDEX_BITS + 3*COORD +: T_BITS])};
            end
        endfunction

        function void check_result(logic [M_W-1:0] data);
            string names [3];
            point_t exp_p;
            point_t got;
            names = '{"curve_x", "curve_y", "curve_z"};
            got = data[3*COORD-1:0];
            if (expected_points.size() == 0) begin
                $error("curve point %h arrived with no evaluation outstanding", got);
                errors++;
            end
            else begin
                exp_p = expected_points.pop_front();
                for (int c = 0; c < 3; c++) begin
                    if (got[c] !== exp_p[c]) begin
                        $error("%s: expected %0d, actual %0d", names[c],
                               $signed(exp_p[c]), $signed(got[c]));
                        errors++;
                    end
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [DEG_BITS-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;

    curve_scoreboard sb = new();
    int cycle_count = 0;
    int burst_left = 0;
    int items_sent = 0;
    int stall_count = 0;
    int stall_mode = 0;

    bezier_curve_point_eval u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Both monitors sample at the edge, so they see the values that the transfer used.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_input(s_tuser, s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // The receiver switches between always ready, random, mostly stalled and periodic.
    always @(posedge clk)
    begin
        if (stall_count == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_count <= $urandom_range(20, 150);
        end
        else
        begin
            stall_count <= stall_count - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ((cycle_count % 5) < 2);
        endcase
    end

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 7))
            0: return coord_t'(32767);
            1: return coord_t'(-32768);
            2: return coord_t'($signed($urandom_range(0, 511)) - 256);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic logic [T_BITS-1:0] rand_param();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return T_ONE;
            2: return T_ONE - T_BITS'(1);
            3: return T_BITS'($urandom_range(65537, 131071));
            4: return T_BITS'($urandom_range(0, 255));
            default: return T_BITS'($urandom_range(0, 65536));
        endcase
    endfunction

    // Sends one item, opening a new burst after a random gap when the current one is used up.
    task automatic push_item(req_t req, logic [INDEX_BITS-1:0] idx, coord_t x, coord_t y,
                             coord_t z, logic [T_BITS-1:0] t);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 15) == 0) ? 200 : $urandom_range(1, 12);
        end
        s_tuser <= req;
        s_tdata <= {{(S_W - INDEX_BITS - 3*COORD - T_BITS){1'b0}}, t, z, y, x, idx};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        items_sent++;
    endtask

    task automatic load_point(int idx, coord_t x, coord_t y, coord_t z);
        push_item(REQ_LOAD, INDEX_BITS'(idx), x, y, z, rand_param());
    endtask

    task automatic eval_at(logic [T_BITS-1:0] t);
        push_item(REQ_EVAL, INDEX_BITS'($urandom), rand_coord(), rand_coord(), rand_coord(), t);
    endtask

    // Waits until every evaluation has returned and the engine has had time to go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_degree(logic [DEG_BITS-1:0] d);
        cfg_wdata <= d;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_degree(d);
    endtask

    initial
    begin
        int deg;
        int target;
        int evals;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every slot is loaded before the first evaluation, so no unwritten point is read.
        load_point(0, coord_t'(32767), coord_t'(-32768), coord_t'(0));
        load_point(1, coord_t'(-32768), coord_t'(32767), coord_t'(1));
        load_point(2, coord_t'(0), coord_t'(-1), coord_t'(32767));
        load_point(3, coord_t'(-1), coord_t'(0), coord_t'(-32768));
        for (int i = 4; i < MAX_POINTS_DEF; i++)
            load_point(i, rand_coord(), rand_coord(), rand_coord());
        eval_at('0);
        eval_at(T_ONE);
        eval_at(T_BITS'(32768));
        eval_at(T_BITS'(131071));
        eval_at(T_BITS'(1));
        settle();
        // Degree zero returns point 0 untouched.
        write_degree(DEG_BITS'(0));
        eval_at(T_BITS'(40000));
        settle();
        write_degree(DEG_BITS'(15));
        eval_at(T_BITS'(65535));
        eval_at(T_BITS'(65537));
        settle();
        write_degree(DEG_BITS'(1));
        eval_at(T_BITS'(32768));
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            deg = (p == 0) ? 15 : (p == 1) ? 1 : (p == 2) ? 0 : $urandom_range(0, 15);
            write_degree(DEG_BITS'(deg));
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    // A whole curve: fresh control points, then two to six evaluations at random t.
                    if ($urandom_range(0, 1) == 1)
                        for (int k = 0; k <= deg; k++)
                            load_point(k, rand_coord(), rand_coord(), rand_coord());
                    else
                        for (int k = deg; k >= 0; k--)
                            load_point(k, rand_coord(), rand_coord(), rand_coord());
                    evals = $urandom_range(2, 6);
                    repeat (evals) eval_at(rand_param());
                end
                else if ($urandom_range(0, 1) == 1)
                begin
                    load_point($urandom_range(0, MAX_POINTS_DEF - 1), rand_coord(),
                               rand_coord(), rand_coord());
                end
                else
                begin
                    eval_at(rand_param());
                end
            end
            settle();
        end

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
